>>> rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int FracBits = 30;
  localparam int DataW    = 32;
  // magnitude of a sum of two elements
  localparam int MagW     = 33;
  // numerator scaled by the fraction bits
  localparam int NumW     = MagW + FracBits;
  // radicand scaled by the fraction bits
  localparam int VW       = 34 + FracBits;
  localparam int SqN      = (VW + 1) / 2;
  localparam int SqVW     = 2 * SqN;
  localparam int SW       = SqN + 1;
  localparam int QW       = DataW - 1;
  localparam int HiW      = NumW - QW;

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } sel_e;

  typedef struct packed {
    logic signed [DataW-1:0] m00;
    logic signed [DataW-1:0] m01;
    logic signed [DataW-1:0] m02;
    logic signed [DataW-1:0] m10;
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m20;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] q_w;
    logic signed [DataW-1:0] q_x;
    logic signed [DataW-1:0] q_y;
    logic signed [DataW-1:0] q_z;
    logic [1:0]              case_used;
    logic                    degenerate;
  } out_t;

  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] n;
  } lane_t;

  typedef struct packed {
    sel_e             sel;
    logic             deg;
    lane_t [2:0]      lane;
    logic [SqVW-1:0]  v;
    logic [SqN-1:0]   rem;
    logic [SqN-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [QW-1:0] n;
    logic [SW-1:0] rem;
    logic [QW-1:0] q;
  } dlane_t;

  typedef struct packed {
    sel_e           sel;
    logic           deg;
    logic [SqN-2:0] own;
    logic [SW-1:0]  s;
    dlane_t [2:0]   lane;
  } dv_t;

endpackage

>>> rtl/rmq_front.sv
module rmq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  rmq_pkg::in_t   data_i,
  output logic           vld_o,
  output rmq_pkg::sq_t   data_o
);

  localparam int SumW = 35;

  logic signed [SumW-1:0] one, tr, rad;
  logic signed [SumW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [SumW-1:0] num [3];
  rmq_pkg::sel_e          sel;
  rmq_pkg::sq_t           st_d, st_q;
  logic                   vld_q;
  logic [SumW-1:0]        mag;
  logic [rmq_pkg::VW-1:0] v;

  always_comb begin
    e00 = SumW'(data_i.m00);
    e01 = SumW'(data_i.m01);
    e02 = SumW'(data_i.m02);
    e10 = SumW'(data_i.m10);
    e11 = SumW'(data_i.m11);
    e12 = SumW'(data_i.m12);
    e20 = SumW'(data_i.m20);
    e21 = SumW'(data_i.m21);
    e22 = SumW'(data_i.m22);
    one = SumW'(1) <<< rmq_pkg::FracBits;
    tr  = e00 + e11 + e22;
    priority if (tr > 0) begin
      sel    = rmq_pkg::SEL_W;
      rad    = one + tr;
      num[0] = e21 - e12;
      num[1] = e02 - e20;
      num[2] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      sel    = rmq_pkg::SEL_X;
      rad    = one + e00 - e11 - e22;
      num[0] = e21 - e12;
      num[1] = e01 + e10;
      num[2] = e02 + e20;
    end else if (e11 > e22) begin
      sel    = rmq_pkg::SEL_Y;
      rad    = one + e11 - e00 - e22;
      num[0] = e02 - e20;
      num[1] = e01 + e10;
      num[2] = e12 + e21;
    end else begin
      sel    = rmq_pkg::SEL_Z;
      rad    = one + e22 - e00 - e11;
      num[0] = e10 - e01;
      num[1] = e02 + e20;
      num[2] = e12 + e21;
    end
    st_d      = '0;
    st_d.sel  = sel;
    st_d.deg  = (rad <= 0);
    for (int k = 0; k < 3; k++) begin
      mag              = num[k][SumW-1] ? SumW'(-num[k]) : SumW'(num[k]);
      st_d.lane[k].neg = num[k][SumW-1];
      st_d.lane[k].n   = rmq_pkg::NumW'(mag[rmq_pkg::MagW-1:0]) << rmq_pkg::FracBits;
    end
    // a non-positive radicand roots as nothing; the result is cleared later
    v      = st_d.deg ? '0 : (rmq_pkg::VW'(rad[33:0]) << rmq_pkg::FracBits);
    st_d.v = rmq_pkg::SqVW'(v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = st_q;

endmodule

>>> rtl/rmq_sqrt_cell.sv
module rmq_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  rmq_pkg::sq_t  data_i,
  output logic          vld_o,
  output rmq_pkg::sq_t  data_o
);

  logic [rmq_pkg::SqN+1:0] t, trial;
  rmq_pkg::sq_t            st_d, st_q;
  logic                    vld_q;

  // one root bit: bring down two radicand bits, try 4r+1
  always_comb begin
    st_d  = data_i;
    t     = {data_i.rem, data_i.v[rmq_pkg::SqVW-1 -: 2]};
    trial = {data_i.root, 2'b01};
    if (t >= trial) begin
      st_d.rem  = rmq_pkg::SqN'(t - trial);
      st_d.root = {data_i.root[rmq_pkg::SqN-2:0], 1'b1};
    end else begin
      st_d.rem  = t[rmq_pkg::SqN-1:0];
      st_d.root = {data_i.root[rmq_pkg::SqN-2:0], 1'b0};
    end
    st_d.v = data_i.v << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = st_q;

endmodule

>>> rtl/rmq_div_cell.sv
module rmq_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  rmq_pkg::dv_t  data_i,
  output logic          vld_o,
  output rmq_pkg::dv_t  data_o
);

  logic [rmq_pkg::SW:0] t [3];
  rmq_pkg::dv_t         st_d, st_q;
  logic                 vld_q;

  // one quotient bit in each of the three lanes
  always_comb begin
    st_d = data_i;
    for (int k = 0; k < 3; k++) begin
      t[k] = {data_i.lane[k].rem, data_i.lane[k].n[rmq_pkg::QW-1]};
      if (t[k] >= {1'b0, data_i.s}) begin
        st_d.lane[k].rem = rmq_pkg::SW'(t[k] - {1'b0, data_i.s});
        st_d.lane[k].q   = {data_i.lane[k].q[rmq_pkg::QW-2:0], 1'b1};
      end else begin
        st_d.lane[k].rem = t[k][rmq_pkg::SW-1:0];
        st_d.lane[k].q   = {data_i.lane[k].q[rmq_pkg::QW-2:0], 1'b0};
      end
      st_d.lane[k].n = data_i.lane[k].n << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = st_q;

endmodule

>>> rtl/rotation_matrix_to_quaternion.sv
// channel | direction | handshake             | word
// in      | input     | in_valid_i/in_ready_o | in_data_i (nine Q1.30 elements)
// out     | output    | out_valid_o/out_ready_i | out_data_o (w x y z, case, flag)
//
// One matrix a cycle while the output is not stalled; the stages in order:
// a register for case selection, one root bit per square-root cell, an
// overflow check, one quotient bit per divider cell, and the output register.
// The whole chain advances together; it holds while a result waits and
// out_ready_i is low. Reset clears the valid bits only.
module rotation_matrix_to_quaternion (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rmq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rmq_pkg::out_t out_data_o
);

  localparam int SqN = rmq_pkg::SqN;
  localparam int QW  = rmq_pkg::QW;

  logic         en;
  rmq_pkg::sq_t sq_w [SqN+1];
  logic         sv_w [SqN+1];
  rmq_pkg::dv_t dv_w [QW+1];
  logic         dvv_w [QW+1];
  rmq_pkg::dv_t cv_d;
  logic         cv_vld_q;
  rmq_pkg::dv_t cv_q;
  rmq_pkg::out_t out_d, out_q;
  logic          out_vld_q;
  logic [rmq_pkg::HiW-1:0] hi;
  logic [rmq_pkg::DataW-1:0] val [3];
  logic [rmq_pkg::DataW-1:0] own;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  rmq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .data_i (in_data_i),
    .vld_o  (sv_w[0]),
    .data_o (sq_w[0])
  );

  for (genvar i = 0; i < SqN; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sv_w[i]),
      .data_i (sq_w[i]),
      .vld_o  (sv_w[i+1]),
      .data_o (sq_w[i+1])
    );
  end

  // S = 2 * root; quotients of 2^31 and more saturate
  always_comb begin
    cv_d     = '0;
    cv_d.sel = sq_w[SqN].sel;
    cv_d.deg = sq_w[SqN].deg;
    cv_d.own = sq_w[SqN].root[SqN-1:1];
    cv_d.s   = {sq_w[SqN].root, 1'b0};
    hi       = '0;
    for (int k = 0; k < 3; k++) begin
      hi                = sq_w[SqN].lane[k].n[rmq_pkg::NumW-1:QW];
      cv_d.lane[k].neg  = sq_w[SqN].lane[k].neg;
      cv_d.lane[k].ovf  = rmq_pkg::SW'(hi) >= cv_d.s;
      cv_d.lane[k].rem  = rmq_pkg::SW'(hi);
      cv_d.lane[k].n    = sq_w[SqN].lane[k].n[QW-1:0];
      cv_d.lane[k].q    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_vld_q <= 1'b0;
    end else if (en) begin
      cv_vld_q <= sv_w[SqN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cv_q <= cv_d;
    end
  end

  assign dv_w[0]  = cv_q;
  assign dvv_w[0] = cv_vld_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    rmq_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dvv_w[i]),
      .data_i (dv_w[i]),
      .vld_o  (dvv_w[i+1]),
      .data_o (dv_w[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      priority if (dv_w[QW].lane[k].ovf) begin
        val[k] = dv_w[QW].lane[k].neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
      end else if (dv_w[QW].lane[k].neg) begin
        val[k] = -{1'b0, dv_w[QW].lane[k].q};
      end else begin
        val[k] = {1'b0, dv_w[QW].lane[k].q};
      end
    end
    own = rmq_pkg::DataW'(dv_w[QW].own);
    out_d            = '0;
    out_d.case_used  = dv_w[QW].sel;
    out_d.degenerate = dv_w[QW].deg;
    unique case (dv_w[QW].sel)
      rmq_pkg::SEL_W: begin
        out_d.q_w = own;    out_d.q_x = val[0];
        out_d.q_y = val[1]; out_d.q_z = val[2];
      end
      rmq_pkg::SEL_X: begin
        out_d.q_w = val[0]; out_d.q_x = own;
        out_d.q_y = val[1]; out_d.q_z = val[2];
      end
      rmq_pkg::SEL_Y: begin
        out_d.q_w = val[0]; out_d.q_x = val[1];
        out_d.q_y = own;    out_d.q_z = val[2];
      end
      rmq_pkg::SEL_Z: begin
        out_d.q_w = val[0]; out_d.q_x = val[1];
        out_d.q_y = val[2]; out_d.q_z = own;
      end
      default: begin
        out_d.q_w = '0; out_d.q_x = '0;
        out_d.q_y = '0; out_d.q_z = '0;
      end
    endcase
    // drop the components of a degenerate matrix
    if (dv_w[QW].deg) begin
      out_d.q_w = '0; out_d.q_x = '0;
      out_d.q_y = '0; out_d.q_z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvv_w[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_deg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.q_w == '0 && out_data_o.q_x == '0 &&
      out_data_o.q_y == '0 && out_data_o.q_z == '0)
    else $error("degenerate word carries non-cleared components");

  a_trace_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.case_used == rmq_pkg::SEL_W |-> !out_data_o.degenerate)
    else $error("trace case flagged degenerate");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cv_q) && $stable(sq_w[SqN]))
    else $error("pipeline advanced while output stalled");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int Latency   = rmq_pkg::SqN + rmq_pkg::QW + 3;
  localparam int CycleCap  = 400000;
  localparam int RandWords = 700;
  localparam logic signed [31:0] One  = 32'sh4000_0000;
  localparam logic signed [31:0] MaxV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MinV = 32'sh8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rmq_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rmq_pkg::out_t out_data_o;

  rmq_pkg::out_t quat_q[$];
  int   n_bad = 0;
  int   cycles = 0;
  bit   feed_done = 1'b0;

  rotation_matrix_to_quaternion DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(bit neg, logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? MinV : -$signed(mag[31:0]);
    return (mag > 64'h7fff_ffff) ? MaxV : $signed(mag[31:0]);
  endfunction

  function automatic logic signed [31:0] frac_div(longint num, logic [63:0] s);
    bit neg;
    logic [63:0] mag;
    neg = num < 0;
    mag = neg ? -num : num;
    return clamp32(neg, (mag << rmq_pkg::FracBits) / s);
  endfunction

  function automatic rmq_pkg::out_t to_quat(rmq_pkg::in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
    longint nw, nx, ny, nz;
    logic [63:0] s;
    rmq_pkg::sel_e sel;
    rmq_pkg::out_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      sel = rmq_pkg::SEL_W; rad = One + tr;
      nw = 0; nx = a21 - a12; ny = a02 - a20; nz = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      sel = rmq_pkg::SEL_X; rad = One + a00 - a11 - a22;
      nw = a21 - a12; nx = 0; ny = a01 + a10; nz = a02 + a20;
    end else if (a11 > a22) begin
      sel = rmq_pkg::SEL_Y; rad = One + a11 - a00 - a22;
      nw = a02 - a20; nx = a01 + a10; ny = 0; nz = a12 + a21;
    end else begin
      sel = rmq_pkg::SEL_Z; rad = One + a22 - a00 - a11;
      nw = a10 - a01; nx = a02 + a20; ny = a12 + a21; nz = 0;
    end
    r = '0;
    r.case_used = sel;
    if (rad <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    s = 64'd2 * root_floor(64'(rad) << rmq_pkg::FracBits);
    r.q_w = frac_div(nw, s);
    r.q_x = frac_div(nx, s);
    r.q_y = frac_div(ny, s);
    r.q_z = frac_div(nz, s);
    case (sel)
      rmq_pkg::SEL_W: r.q_w = clamp32(1'b0, s >> 2);
      rmq_pkg::SEL_X: r.q_x = clamp32(1'b0, s >> 2);
      rmq_pkg::SEL_Y: r.q_y = clamp32(1'b0, s >> 2);
      default: r.q_z = clamp32(1'b0, s >> 2);
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] rand_elem();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return MaxV;
    if (p == 1) return MinV;
    if (p < 5) return $signed($urandom_range(0, 2 * 32'h4000_0000)) - One;
    return $signed($urandom());
  endfunction

  // nine random elements, or a rotation-like matrix about one axis with random cos and sin, signs and jitter
  function automatic rmq_pkg::in_t rand_matrix();
    rmq_pkg::in_t m;
    int p;
    logic signed [31:0] c, sn, j;
    p = $urandom_range(0, 9);
    if (p >= 7) begin
      m.m00 = rand_elem(); m.m01 = rand_elem(); m.m02 = rand_elem();
      m.m10 = rand_elem(); m.m11 = rand_elem(); m.m12 = rand_elem();
      m.m20 = rand_elem(); m.m21 = rand_elem(); m.m22 = rand_elem();
      return m;
    end
    c = $signed($urandom_range(0, 2 * 32'h4000_0000)) - One;
    sn = $signed($urandom_range(0, 32'h4000_0000));
    if ($urandom_range(0, 1)) sn = -sn;
    j = $signed($urandom_range(0, 255)) - 128;
    m = '0;
    case (p % 3)
      0: begin
        m.m00 = One - j; m.m11 = c; m.m22 = c + j; m.m12 = -sn; m.m21 = sn;
      end
      1: begin
        m.m11 = One - j; m.m00 = c; m.m22 = c + j; m.m02 = sn; m.m20 = -sn;
      end
      default: begin
        m.m22 = One - j; m.m00 = c; m.m11 = c + j; m.m01 = -sn; m.m10 = sn;
      end
    endcase
    if (p < 3) begin
      m.m00 = -m.m00; m.m11 = -m.m11;
    end
    return m;
  endfunction

  task automatic send_word(rmq_pkg::in_t m, rmq_pkg::out_t want, bit typed);
    int g;
    g = gap_len();
    // drop valid across an idle gap
    if (g > 0) in_valid_i <= 1'b0;
    repeat (g) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    quat_q.push_back(typed ? want : to_quat(m));
  endtask

  typedef struct {
    rmq_pkg::in_t  m;
    rmq_pkg::out_t q;
    bit            typed;
  } row_t;

  row_t rows[$];

  function automatic rmq_pkg::in_t diag(logic signed [31:0] a, logic signed [31:0] b,
                                        logic signed [31:0] c);
    rmq_pkg::in_t m;
    m = '0;
    m.m00 = a; m.m11 = b; m.m22 = c;
    return m;
  endfunction

  function automatic rmq_pkg::out_t quat(logic signed [31:0] w, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] z,
                                         rmq_pkg::sel_e sel, bit deg);
    rmq_pkg::out_t r;
    r.q_w = w; r.q_x = x; r.q_y = y; r.q_z = z;
    r.case_used = sel; r.degenerate = deg;
    return r;
  endfunction

  initial begin
    rmq_pkg::in_t m;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // identity, half turns, zero, all-negative and extreme diagonals
    rows.push_back('{diag(One, One, One), quat(One, 0, 0, 0, rmq_pkg::SEL_W, 0), 1});
    rows.push_back('{diag(One, -One, -One), quat(0, One, 0, 0, rmq_pkg::SEL_X, 0), 1});
    rows.push_back('{diag(-One, One, -One), quat(0, 0, One, 0, rmq_pkg::SEL_Y, 0), 1});
    rows.push_back('{diag(-One, -One, One), quat(0, 0, 0, One, rmq_pkg::SEL_Z, 0), 1});
    rows.push_back('{diag(0, 0, 0), '0, 0});
    rows.push_back('{diag(-One, -One, -One), '0, 0});
    rows.push_back('{diag(MinV, MinV, MinV), '0, 0});
    rows.push_back('{diag(MinV, MaxV, MaxV), '0, 0});
    rows.push_back('{diag(MaxV, MaxV, MaxV), '0, 0});
    rows.push_back('{diag(MaxV, MinV, MinV), '0, 0});
    rows.push_back('{diag(MinV, MaxV, MinV), '0, 0});
    rows.push_back('{diag(MinV, MinV, MaxV), '0, 0});
    // off-diagonal extremes drive the quotients into saturation, then small ones
    m = diag(MinV, MinV, MaxV);
    m.m01 = MaxV; m.m10 = MaxV; m.m02 = MinV; m.m20 = MinV;
    m.m12 = MaxV; m.m21 = MinV;
    rows.push_back('{m, '0, 0});
    m = diag(-One, -One, -One + 1);
    m.m01 = MinV; m.m10 = MaxV; m.m02 = MaxV; m.m20 = MaxV;
    m.m12 = MinV; m.m21 = MinV;
    rows.push_back('{m, '0, 0});
    m = diag(1, 0, 0);
    m.m12 = MinV; m.m21 = MaxV; m.m01 = MaxV; m.m10 = MinV;
    rows.push_back('{m, '0, 0});
    m = diag(-One, One, One);
    m.m01 = -1; m.m10 = -1; m.m02 = 1; m.m20 = 1;
    rows.push_back('{m, '0, 0});
    // ties on the diagonal fall through to later cases
    rows.push_back('{diag(0, 0, -1), '0, 0});
    rows.push_back('{diag(-5, -5, -5), '0, 0});
    rows.push_back('{diag(-One, 0, 0), '0, 0});
    foreach (rows[i]) send_word(rows[i].m, rows[i].q, rows[i].typed);
    for (int i = 0; i < RandWords; i++) send_word(rand_matrix(), '0, 0);
    in_valid_i <= 1'b0;
    feed_done = 1'b1;
  end

  // receiver: random back-pressure, long stalls now and then
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        hold = gap_len();
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    rmq_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected word %h", out_data_o);
      end else begin
        want = quat_q.pop_front();
        if (out_data_o !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: want w=%h x=%h y=%h z=%h c=%0d d=%0b",
                     want.q_w, want.q_x, want.q_y, want.q_z,
                     want.case_used, want.degenerate,
                     "\n          got  w=%h x=%h y=%h z=%h c=%0d d=%0b",
                     out_data_o.q_w, out_data_o.q_x, out_data_o.q_y,
                     out_data_o.q_z, out_data_o.case_used, out_data_o.degenerate);
        end
      end
    end
  end

  initial begin
    wait (feed_done && quat_q.size() == 0);
    repeat (Latency + 50) @(posedge clk_i);
    if (n_bad == 0 && quat_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleCap) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_div_cell.sv
rtl/rotation_matrix_to_quaternion.sv
tb/sv/tb_top.sv
